// ----- design/olist_pkg.sv -----
// shared types and constants for the ordered list engine
// no dependencies; imported by every module of the block
package olist_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  // fixed field widths of the item ports
  localparam int OP_BITS    = 3;
  localparam int DATA_BITS  = 32;
  localparam int POS_BITS   = 5;
  localparam int FPOS_BITS  = 4;
  localparam int COUNT_BITS = 5;
  localparam int CMP_BITS   = CNT_BITS + POS_BITS;

  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND    = 3'd0,
    OP_FIND      = 3'd1,
    OP_READ      = 3'd2,
    OP_ERASE_AT  = 3'd3,
    OP_ERASE_ALL = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_cmd_t;

  // broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    cell_cmd_t           cmd;
    logic [CNT_BITS-1:0] ptr;
  } cell_ctl_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [DATA_BITS-1:0] value;
    logic [POS_BITS-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [FPOS_BITS-1:0]  found_position;
    logic [DATA_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

endpackage

// ----- design/olist_cell.sv -----
// one slot of the list chain: holds an entry, compares it to the key
// and takes its right-hand neighbor's entry on a shift; uses olist_pkg
module olist_cell import olist_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IDX_BITS-1:0]   cell_idx,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [VALUE_BITS-1:0] nbr_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  hit
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  logic [CNT_BITS-1:0]   idx_ext;

  assign idx_ext = CNT_BITS'(cell_idx);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.cmd)
      CELL_HOLD: begin
      end
      CELL_APPEND: begin
        if (idx_ext == ctl.ptr) val_nxt = key;
      end
      // every slot from the pointer up moves down one place
      CELL_SHIFT: begin
        if (idx_ext >= ctl.ptr) val_nxt = nbr_val;
      end
      CELL_CLEAR: begin
        val_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
  assign hit = (val_r == key);

endmodule

// ----- design/ordered_list_engine_core.sv -----
// ordered list engine top level: command sequencer over a chain of list cells
// depends on olist_pkg and olist_cell
//
// usage:
//   in_valid/in_ready take one command item (operation, value, position);
//   out_valid/out_ready return exactly one result item per command
//   (ok, found_position, read_value, count).
//   commands run one at a time. append, read, erase-at, clear and unused
//   codes finish in the execute state entered on accept; the result is
//   registered into the output register, or the holding register on a stall.
//   find walks the chain one slot a cycle and stops at the first match.
//   erase-all walks the chain one step a cycle, each step either passing a
//   slot or closing the gap of a match with a shift of every slot from the
//   match up.
//   reset (synchronous, rst_n low) empties the list and zeroes every slot;
//   no clearing pass follows, the block is ready on the first cycle after.
//   a finished result sits in the output register; while the receiver
//   stalls, the next command is still taken and run, and its result waits
//   in a holding register until the output register frees up.
module ordered_list_engine_core import olist_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t              state_r, state_nxt;
  in_item_t            cmd_r, cmd_nxt;
  logic [CNT_BITS-1:0] len_r, len_nxt;
  logic [CNT_BITS-1:0] j_r, j_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  cell_ctl_t             ctl;
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   hit_vec;

  op_t                   op;
  logic                  pos_ok;
  logic                  finish;
  logic                  slot_free;
  out_item_t             done_res;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_BITS-1:0] nbr;
      if (g == CAPACITY - 1) begin : g_last
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_val[g+1];
      end
      olist_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_BITS'(g)),
        .ctl      (ctl),
        .key      (cmd_r.value[VALUE_BITS-1:0]),
        .nbr_val  (nbr),
        .val      (cell_val[g]),
        .hit      (hit_vec[g])
      );
    end
  endgenerate

  assign op        = op_t'(cmd_r.operation);
  assign pos_ok    = CMP_BITS'(cmd_r.position) < CMP_BITS'(len_r);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    j_nxt         = j_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ctl.cmd       = CELL_HOLD;
    ctl.ptr       = len_r;
    finish        = 1'b0;
    done_res      = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_item;
          j_nxt     = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op)
          OP_APPEND: begin
            finish = 1'b1;
            if (len_r < CAP_CNT) begin
              ctl.cmd     = CELL_APPEND;
              len_nxt     = len_r + 1'b1;
              done_res.ok = 1'b1;
            end
          end
          OP_FIND: begin
            // one slot per cycle, first match wins
            if (j_r >= len_r) begin
              finish = 1'b1;
            end else if (hit_vec[j_r[IDX_BITS-1:0]]) begin
              finish                  = 1'b1;
              done_res.ok             = 1'b1;
              done_res.found_position = FPOS_BITS'(j_r);
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
          OP_READ: begin
            finish = 1'b1;
            if (pos_ok) begin
              done_res.ok         = 1'b1;
              done_res.read_value =
                DATA_BITS'(cell_val[cmd_r.position[IDX_BITS-1:0]]);
            end
          end
          OP_ERASE_AT: begin
            finish = 1'b1;
            if (pos_ok) begin
              ctl.cmd     = CELL_SHIFT;
              ctl.ptr     = CNT_BITS'(cmd_r.position);
              len_nxt     = len_r - 1'b1;
              done_res.ok = 1'b1;
            end
          end
          OP_ERASE_ALL: begin
            // a match closes its gap and is looked at again in place
            if (j_r >= len_r) begin
              finish      = 1'b1;
              done_res.ok = 1'b1;
            end else if (hit_vec[j_r[IDX_BITS-1:0]]) begin
              ctl.cmd = CELL_SHIFT;
              ctl.ptr = j_r;
              len_nxt = len_r - 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
          OP_CLEAR: begin
            finish      = 1'b1;
            ctl.cmd     = CELL_CLEAR;
            len_nxt     = '0;
            done_res.ok = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        done_res.count = COUNT_BITS'(len_nxt);
        if (finish) begin
          if (slot_free) begin
            out_nxt       = done_res;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            res_nxt   = done_res;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_CNT)
    else $error("list length beyond capacity");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r < CAP_CNT) |-> (cell_val[len_r[IDX_BITS-1:0]] == '0))
    else $error("slot past the end of the list is not zero");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted item did not start");

  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op == OP_APPEND && len_r < CAP_CNT)
      |=> (len_r == $past(len_r) + 1'b1))
    else $error("append did not grow the list");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && finish && slot_free)
      |=> (out_valid && out_item.count == COUNT_BITS'(len_r)))
    else $error("result count differs from list length");
`endif

endmodule
